/* src/fra_pkg.sv */
// fra_pkg: shared constants and types for the fraction arithmetic unit.
// No dependencies.
`default_nettype none
package fra_pkg;
    localparam int OpBits  = 16;
    localparam int ProdBits = 2 * OpBits;
    localparam int SumBits  = ProdBits + 1;
    localparam int NumBits  = 32;
    localparam int DenBits  = 31;
    localparam int CmdBits  = 2;
    localparam int QDepth   = 2;

    localparam logic [CmdBits-1:0] CMD_ADD = 2'd0;
    localparam logic [CmdBits-1:0] CMD_SUB = 2'd1;
    localparam logic [CmdBits-1:0] CMD_MUL = 2'd2;
    localparam logic [CmdBits-1:0] CMD_DIV = 2'd3;

    // job handed from front to back
    typedef struct packed {
        logic signed [SumBits-1:0]  num;
        logic signed [ProdBits-1:0] den;
    } fra_job_t;
endpackage
`default_nettype wire

/* src/fra_front.sv */
// fra_front: takes an input word, registers the operand products, then forms the job.
// Depends on fra_pkg.
`default_nettype none
module fra_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fra_pkg::CmdBits-1:0]   cmd,
    input  wire logic signed [fra_pkg::OpBits-1:0] an,
    input  wire logic signed [fra_pkg::OpBits-1:0] ad,
    input  wire logic signed [fra_pkg::OpBits-1:0] bn,
    input  wire logic signed [fra_pkg::OpBits-1:0] bd,
    output logic                               job_valid,
    input  wire logic                          job_ready,
    output fra_pkg::fra_job_t                  job
);
    import fra_pkg::*;

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CmdBits-1:0]         cmd_reg;
    logic signed [ProdBits-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [OpBits-1:0]   m0a, m0b, m1a, m1b;
    fra_job_t                   job_reg, job_next;

    assign in_ready  = !busy_reg && !done_reg;
    assign job_valid = done_reg;
    assign job       = job_reg;

    // one multiplier per product; register after each
    always_comb begin
        m0a = an; m0b = bd; m1a = bn; m1b = ad;
        case (cmd)
            CMD_MUL: begin m0b = bn; m1a = ad; m1b = bd; end
            CMD_DIV: begin m1a = ad; m1b = bn; end
            default: ;
        endcase
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        job_next  = job_reg;
        if (in_valid && in_ready) busy_next = 1'b1;
        if (busy_reg) begin
            busy_next = 1'b0;
            done_next = 1'b1;
            case (cmd_reg)
                CMD_ADD: begin
                    job_next.num = SumBits'(p0_reg) + SumBits'(p1_reg);
                    job_next.den = p2_reg;
                end
                CMD_SUB: begin
                    job_next.num = SumBits'(p0_reg) - SumBits'(p1_reg);
                    job_next.den = p2_reg;
                end
                CMD_MUL: begin
                    job_next.num = SumBits'(p0_reg);
                    job_next.den = p1_reg;
                end
                default: begin
                    job_next.num = SumBits'(p0_reg);
                    job_next.den = p1_reg;
                end
            endcase
        end
        if (done_reg && job_ready) done_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        job_reg <= job_next;
        if (in_valid && in_ready) begin
            cmd_reg <= cmd;
            p0_reg  <= m0a * m0b;
            p1_reg  <= m1a * m1b;
            p2_reg  <= ad * bd;
        end
    end
endmodule
`default_nettype wire

/* src/fra_queue.sv */
// fra_queue: short FIFO between front and back.
// Depends on fra_pkg.
`default_nettype none
module fra_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire fra_pkg::fra_job_t wr_data,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output fra_pkg::fra_job_t      rd_data
);
    import fra_pkg::*;
    localparam int PtrBits = $clog2(QDepth);

    fra_job_t           mem_reg [QDepth];
    logic [PtrBits-1:0] wp_reg, rp_reg;
    logic [PtrBits:0]   cnt_reg;
    logic               wr_en, rd_en;

    assign wr_ready = cnt_reg != (PtrBits+1)'(QDepth);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrBits+1)'(wr_en) - (PtrBits+1)'(rd_en);
        end
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

/* src/fra_back.sv */
// fra_back: binary GCD, then two restoring divisions; output register.
// Depends on fra_pkg. A zero numerator or denominator skips the GCD and divisions.
`default_nettype none
module fra_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        job_valid,
    output logic                             job_ready,
    input  wire fra_pkg::fra_job_t           job,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [fra_pkg::NumBits-1:0]      out_num,
    output logic [fra_pkg::DenBits-1:0]      out_den
);
    import fra_pkg::*;
    localparam int W  = SumBits;
    localparam int CB = $clog2(W + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SHF  = 3'd1;
    localparam logic [2:0] ST_GCD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    st_reg, st_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next;
    logic [CB-1:0] sh_reg, sh_next;
    logic [W-1:0]  g_reg, g_next;
    logic [W-1:0]  nm_reg, nm_next, dm_reg, dm_next;
    logic          nneg_reg, nneg_next, dneg_reg, dneg_next;
    logic          sel_reg, sel_next;
    logic [CB-1:0] bit_reg, bit_next;
    logic [W-1:0]  rem_reg, rem_next, q_reg, q_next;
    logic [W-1:0]  nq_reg, nq_next;
    logic [NumBits-1:0] on_reg, on_next;
    logic [DenBits-1:0] od_reg, od_next;
    logic [W-1:0]  jn, jd, rsh, dq;

    assign job_ready = st_reg == ST_IDLE;
    assign out_valid = st_reg == ST_OUT;
    assign out_num   = on_reg;
    assign out_den   = od_reg;

    always_comb begin
        jn = job.num;
        jd = W'(job.den);
        st_next = st_reg; a_next = a_reg; b_next = b_reg; sh_next = sh_reg;
        g_next = g_reg; nm_next = nm_reg; dm_next = dm_reg;
        nneg_next = nneg_reg; dneg_next = dneg_reg; sel_next = sel_reg;
        bit_next = bit_reg; rem_next = rem_reg; q_next = q_reg; nq_next = nq_reg;
        on_next = on_reg; od_next = od_reg;
        rsh = '0; dq = '0;
        case (st_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    nneg_next = jn[W-1];
                    dneg_next = jd[W-1];
                    nm_next = jn[W-1] ? -jn : jn;
                    dm_next = jd[W-1] ? -jd : jd;
                    a_next = nm_next; b_next = dm_next; sh_next = '0;
                    if (jn == '0 || jd == '0) begin
                        on_next = NumBits'(jn);
                        od_next = DenBits'(jd);
                        st_next = ST_OUT;
                    end else st_next = ST_SHF;
                end
            end
            ST_SHF: begin
                if (a_reg[0] | b_reg[0]) begin
                    st_next = ST_GCD;
                end else begin
                    a_next = a_reg >> 1; b_next = b_reg >> 1;
                    sh_next = sh_reg + 1'b1;
                end
            end
            ST_GCD: begin
                // one strip or compare-subtract per cycle
                if (!a_reg[0]) a_next = a_reg >> 1;
                else if (b_reg == '0) begin
                    g_next = a_reg << sh_reg;
                    sel_next = 1'b0;
                    bit_next = CB'(W);
                    rem_next = '0; q_next = '0;
                    st_next = ST_DIV;
                end else if (!b_reg[0]) b_next = b_reg >> 1;
                else if (a_reg > b_reg) begin
                    a_next = b_reg; b_next = a_reg - b_reg;
                end else b_next = b_reg - a_reg;
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                dq = sel_reg ? dm_reg : nm_reg;
                rsh = {rem_reg[W-2:0], dq[bit_reg - 1'b1]};
                if (rsh >= g_reg) begin
                    rem_next = rsh - g_reg;
                    q_next = {q_reg[W-2:0], 1'b1};
                end else begin
                    rem_next = rsh;
                    q_next = {q_reg[W-2:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == CB'(1)) begin
                    if (!sel_reg) begin
                        nq_next = nneg_reg ? -q_next : q_next;
                        sel_next = 1'b1; bit_next = CB'(W);
                        rem_next = '0; q_next = '0;
                    end else begin
                        on_next = NumBits'(nq_reg);
                        od_next = DenBits'(dneg_reg ? -q_next : q_next);
                        st_next = ST_OUT;
                    end
                end
            end
            ST_OUT: if (out_ready) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= ST_IDLE;
        else st_reg <= st_next;
        a_reg <= a_next; b_reg <= b_next; sh_reg <= sh_next; g_reg <= g_next;
        nm_reg <= nm_next; dm_reg <= dm_next; nneg_reg <= nneg_next;
        dneg_reg <= dneg_next; sel_reg <= sel_next; bit_reg <= bit_next;
        rem_reg <= rem_next; q_reg <= q_next; nq_reg <= nq_next;
        on_reg <= on_next; od_reg <= od_next;
    end
endmodule
`default_nettype wire

/* src/fraction_arith_reduce_unit.sv */
// fraction_arith_reduce_unit: rational add/sub/mul/div with GCD reduction.
// Front forms products, a 2-entry queue, back runs binary GCD (one step
// per cycle) then two restoring divisions; one word in the back at a time.
// Zero numerator or denominator skips reduction.
// Synchronous active-low reset clears all control state. Uses fra_pkg.
`default_nettype none
module fraction_arith_reduce_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[1:0], a_num[17:2], a_den[33:18], b_num[49:34], b_den[65:50]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // res_num[31:0], res_den[62:32]
    output logic [63:0]      m_tdata
);
    import fra_pkg::*;

    logic     fj_valid, fj_ready, qj_valid, qj_ready;
    fra_job_t fj, qj;
    logic [NumBits-1:0] rn;
    logic [DenBits-1:0] rd;

    fra_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .cmd(s_tdata[1:0]), .an(s_tdata[17:2]), .ad(s_tdata[33:18]),
        .bn(s_tdata[49:34]), .bd(s_tdata[65:50]),
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    fra_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
    );

    fra_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_num(rn), .out_den(rd)
    );

    assign m_tdata = {1'b0, rd, rn};
endmodule
`default_nettype wire
